@@ rtl/shp3_pkg.sv @@
// ----------------------------------------------------------------------------
// shp3_pkg: shared constants, codes and helpers for the 3x3 sharpen stream
// Frame limits, register indexes, mode codes and small arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package shp3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int DIM_W     = 12;                          // size register width
  localparam int COL_W     = $clog2(MAX_WIDTH);           // line store address
  localparam int ROW_W     = $clog2(MAX_HEIGHT) + 1;      // row may run to h+1
  localparam int COUNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int TOTAL_W   = COUNT_W + 1;
  localparam int PIX_W     = 24;
  localparam int NUM_W     = 13;                          // signed numerator
  localparam int CFG_IDX_W = 3;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_UNSHARP = 2'd1,
    MODE_LAPLACE = 2'd2,
    MODE_RSVD    = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;

  // saturate a size register to 1..lim
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > lim) r = lim;
    return r;
  endfunction

  // floor(n/6) for n < 4096: reciprocal 2731/2^14, exact over this range
  function automatic logic [DIM_W-1:0] div6(input logic [DIM_W-1:0] n);
    logic [2*DIM_W-1:0] p;
    p = {{DIM_W{1'b0}}, n} * (2*DIM_W)'(2731);
    return {2'b00, p[23:14]};
  endfunction

  function automatic logic [7:0] sat8(input logic [DIM_W-1:0] q);
    return (q > DIM_W'(255)) ? 8'hFF : q[7:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/sharpen_3x3_stream.sv @@
// ----------------------------------------------------------------------------
// sharpen_3x3_stream: streaming 3x3 unsharp / laplacian sharpening filter
// Two line stores (synchronous RAM) feed a 3x3 window; one result per frame
// position in raster order, borders copied, off mode passes pixels through.
// ----------------------------------------------------------------------------
// Pipeline: the word that releases a result passes the line store read, window
//   shift, numerator and divide/clamp steps, then the output register.
// Throughput: one word per cycle; the line stores take one read and one write
//   a cycle. Input stalls only while the output register is held by tready,
//   and in the cycle after a configuration write (frame size product).
// Reset: synchronous, clears registers to their defaults, counters, window
//   and pipeline valids; line store contents are not cleared.
`default_nettype none

module sharpen_3x3_stream import shp3_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [PIX_W-1:0]     s_axis_tdata,   // red_in, green_in, blue_in
  input  wire logic [0:0]           s_axis_tuser,   // op (1 = flush tick)
  // output stream
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [PIX_W-1:0]     m_axis_tdata,   // red_out, green_out, blue_out
  output      logic                 m_axis_tlast,   // frame_end
  // configuration write channel
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  mode_t              sharpen_mode;
  logic               gray_only;
  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic               cfg_settle;   // total below is registered from the sizes, so it trails a write
  logic [TOTAL_W-1:0] total;        // positions per frame

  logic               cfg_write;
  logic               cfg_hit;      // a write to a real register restarts the frame
  logic [DIM_W-1:0]   eff_w;
  logic [DIM_W-1:0]   eff_h;
  logic [2*DIM_W-1:0] area;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_write && (cfg_index == REG_MODE || cfg_index == REG_GRAY ||
                                   cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  assign eff_w = clamp_dim(frame_width,  DIM_W'(MAX_WIDTH));
  assign eff_h = clamp_dim(frame_height, DIM_W'(MAX_HEIGHT));
  assign area  = eff_w * eff_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      sharpen_mode <= MODE_OFF;
      gray_only    <= 1'b0;
      frame_width  <= DIM_W'(RESET_WIDTH);
      frame_height <= DIM_W'(RESET_HEIGHT);
      cfg_settle   <= 1'b0;
      total        <= TOTAL_W'(RESET_WIDTH * RESET_HEIGHT);
    end else begin
      cfg_settle <= cfg_write;
      total      <= area[TOTAL_W-1:0];
      if (cfg_write) begin
        case (cfg_index)
          REG_MODE:   sharpen_mode <= mode_t'(cfg_data[1:0]);
          REG_GRAY:   gray_only    <= cfg_data[0];
          REG_WIDTH:  frame_width  <= cfg_data;
          REG_HEIGHT: frame_height <= cfg_data;
          default: ;  // writes past the register list are dropped
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: all stages advance together when the output register
  // is empty or being taken.
  // --------------------------------------------------------------------------
  logic pipe_en;
  logic accept;

  assign pipe_en       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = pipe_en && !cfg_settle;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Stage 0: position tracking and line store read
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]   in_column;
  logic [ROW_W-1:0]   in_row;
  logic [COUNT_W-1:0] out_count;

  logic               windowed;
  logic               is_flush;
  logic [PIX_W-1:0]   px0;
  logic               restart0;
  logic [COL_W-1:0]   c0;
  logic [ROW_W-1:0]   r0;
  logic [COUNT_W-1:0] oc0;
  logic               push0;
  logic               emit0;
  logic               last0;
  logic               interior0;
  logic               fwd0;
  logic [DIM_W-1:0]   col_inc;
  logic [ROW_W-1:0]   pr0;
  logic [DIM_W-1:0]   pc0;
  logic [TOTAL_W-1:0] oc_inc;

  logic [COL_W-1:0]   in_column_next;
  logic [ROW_W-1:0]   in_row_next;
  logic [COUNT_W-1:0] out_count_next;

  // stage 1 registers, declared here for the forwarding compare
  logic               v1;
  logic               push1;
  logic               emit1;
  logic               interior1;
  logic               last1;
  logic               pass1;
  logic [PIX_W-1:0]   px1;
  logic [COL_W-1:0]   col1;
  logic               fwd1;

  always_comb begin
    windowed = (sharpen_mode == MODE_UNSHARP || sharpen_mode == MODE_LAPLACE) &&
               eff_w >= DIM_W'(3) && eff_h >= DIM_W'(3);
    is_flush = s_axis_tuser[0];
    px0      = {gray_only ? 8'h00 : s_axis_tdata[23:16],
                gray_only ? 8'h00 : s_axis_tdata[15:8],
                s_axis_tdata[7:0]};

    // a pixel after the frame is complete starts a new frame; pending
    // results are dropped
    restart0 = windowed && !is_flush && (in_row >= ROW_W'(eff_h));
    c0       = restart0 ? '0 : in_column;
    r0       = restart0 ? '0 : in_row;
    oc0      = restart0 ? '0 : out_count;

    // flush ticks only feed filler once the whole frame is in
    push0 = windowed && (!is_flush || in_row >= ROW_W'(eff_h));
    if (windowed) begin
      emit0 = push0 && (r0 >= ROW_W'(2) || (r0 == ROW_W'(1) && c0 != '0));
    end else begin
      emit0 = !is_flush;
    end
    oc_inc = {1'b0, oc0} + TOTAL_W'(1);
    last0  = emit0 && (oc_inc == total);

    // window center lags the input by one row and one column
    if (c0 != '0) begin
      pr0 = r0 - ROW_W'(1);
      pc0 = DIM_W'(c0) - DIM_W'(1);
    end else begin
      pr0 = r0 - ROW_W'(2);
      pc0 = eff_w - DIM_W'(1);
    end
    interior0 = (pr0 != '0) && ({1'b0, pr0} + (ROW_W+1)'(2) <= (ROW_W+1)'(eff_h)) &&
                (pc0 != '0) && ({1'b0, pc0} + (DIM_W+1)'(2) <= {1'b0, eff_w});

    // same column still being written back by stage 1
    fwd0 = v1 && push1 && (col1 == c0);

    col_inc        = DIM_W'(c0) + DIM_W'(1);
    in_column_next = in_column;
    in_row_next    = in_row;
    out_count_next = emit0 ? oc_inc[COUNT_W-1:0] : oc0;
    if (push0) begin
      if (col_inc >= eff_w) begin
        in_column_next = '0;
        in_row_next    = r0 + ROW_W'(1);
      end else begin
        in_column_next = col_inc[COL_W-1:0];
        in_row_next    = r0;
      end
    end
    if (last0) begin
      in_column_next = '0;
      in_row_next    = '0;
      out_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_column <= '0;
      in_row    <= '0;
      out_count <= '0;
    end else if (accept) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
      out_count <= out_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Line stores: read at stage 0, written back at stage 1
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] line_above     [MAX_WIDTH];
  logic [PIX_W-1:0] line_two_above [MAX_WIDTH];
  logic [PIX_W-1:0] rd_above;
  logic [PIX_W-1:0] rd_two;
  logic [PIX_W-1:0] wr_b;     // last values written, for same-column forwarding
  logic [PIX_W-1:0] wr_px;
  logic [PIX_W-1:0] a1;
  logic [PIX_W-1:0] b1;
  logic             shift1;

  always_ff @(posedge clk) begin
    if (accept && push0) begin
      rd_above <= line_above[c0];
      rd_two   <= line_two_above[c0];
    end
  end

  assign a1     = fwd1 ? wr_b  : rd_two;
  assign b1     = fwd1 ? wr_px : rd_above;
  assign shift1 = pipe_en && v1 && push1;

  always_ff @(posedge clk) begin
    if (shift1) begin
      line_two_above[col1] <= b1;
      line_above[col1]     <= px1;
      wr_b                 <= b1;
      wr_px                <= px1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (pipe_en) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      push1     <= push0;
      emit1     <= emit0;
      interior1 <= interior0;
      last1     <= last0;
      pass1     <= !windowed;
      px1       <= px0;
      col1      <= c0;
      fwd1      <= fwd0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: 3x3 window shift (rows top to bottom, columns left to right)
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] window_regs [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) window_regs[k] <= '0;
    end else if (shift1) begin
      window_regs[0] <= window_regs[1];
      window_regs[1] <= window_regs[2];
      window_regs[2] <= a1;
      window_regs[3] <= window_regs[4];
      window_regs[4] <= window_regs[5];
      window_regs[5] <= b1;
      window_regs[6] <= window_regs[7];
      window_regs[7] <= window_regs[8];
      window_regs[8] <= px1;
    end
  end

  logic             v2;
  logic             interior2;
  logic             last2;
  logic             pass2;
  logic [PIX_W-1:0] px2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (pipe_en) begin
      v2 <= v1 && emit1;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      interior2 <= interior1;
      last2     <= last1;
      pass2     <= pass1;
      px2       <= px1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: numerators. Unsharp: 15v - sum9. Laplacian: 6v - N - S - E - W.
  // --------------------------------------------------------------------------
  logic signed [NUM_W-1:0] num2 [3];

  always_comb begin
    logic [DIM_W-1:0] v;
    logic [DIM_W-1:0] sum9;
    logic [DIM_W-1:0] sum4;
    logic [DIM_W-1:0] v15;
    logic [DIM_W-1:0] v6;
    for (int ch = 0; ch < 3; ch++) begin
      v    = {4'h0, window_regs[4][ch*8 +: 8]};
      sum9 = '0;
      for (int k = 0; k < 9; k++) sum9 = sum9 + {4'h0, window_regs[k][ch*8 +: 8]};
      sum4 = {4'h0, window_regs[1][ch*8 +: 8]} + {4'h0, window_regs[7][ch*8 +: 8]} +
             {4'h0, window_regs[3][ch*8 +: 8]} + {4'h0, window_regs[5][ch*8 +: 8]};
      v15  = (v << 4) - v;
      v6   = (v << 2) + (v << 1);
      if (sharpen_mode == MODE_UNSHARP) begin
        num2[ch] = $signed({1'b0, v15}) - $signed({1'b0, sum9});
      end else begin
        num2[ch] = $signed({1'b0, v6}) - $signed({1'b0, sum4});
      end
    end
  end

  logic                    v3;
  logic                    last3;
  logic                    filt3;
  logic [PIX_W-1:0]        data3;
  logic signed [NUM_W-1:0] num3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (pipe_en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      last3 <= last2;
      filt3 <= !pass2 && interior2;
      data3 <= pass2 ? px2 : window_regs[4];   // border pixels copy the center
      for (int ch = 0; ch < 3; ch++) num3[ch] <= num2[ch];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: divide (by 6 or 2), clamp to 0..255, and output register
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] res3;

  always_comb begin
    logic [DIM_W-1:0] q;
    for (int ch = 0; ch < 3; ch++) begin
      if (num3[ch] < 0) begin
        q = '0;
      end else if (sharpen_mode == MODE_UNSHARP) begin
        q = div6(num3[ch][DIM_W-1:0]);
      end else begin
        q = {1'b0, num3[ch][DIM_W-1:1]};
      end
      if (!filt3) begin
        res3[ch*8 +: 8] = data3[ch*8 +: 8];
      end else if (gray_only && ch != 0) begin
        res3[ch*8 +: 8] = 8'h00;
      end else begin
        res3[ch*8 +: 8] = sat8(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pipe_en) begin
      m_axis_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m_axis_tdata <= res3;
      m_axis_tlast <= last3;
    end
  end

endmodule

`default_nettype wire

@@ rtl/shp3_checker.sv @@
// ----------------------------------------------------------------------------
// shp3_checker: port-level checks for the 3x3 sharpen stream
// Watches the stream and configuration ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module shp3_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  // held result word keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a stalled output blocks the input side
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // input paused in the cycle after a configuration write
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_axis_tready)
    else $error("input taken right after configuration write");

  // with an idle output and no input taken while every pipeline stage drains, no word can appear
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid && !(s_axis_tvalid && s_axis_tready)) [*4] |=> !m_axis_tvalid)
    else $error("unexpected output word");

endmodule

bind sharpen_3x3_stream shp3_checker u_shp3_checker (.*);

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sharpen_3x3_stream
// A directed table (pass-through, size saturation, ignored register, one full
// 3x3 unsharp frame with early and late flushes) followed by random frames in
// all four modes under four idle/stall patterns. Every accepted input word
// runs through a local copy of the filter; output words are compared in order.
// ----------------------------------------------------------------------------
module testbench;
  import shp3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // op field of the input word (travels on tuser)
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // first index past the register list; writes from here up are dropped
  localparam logic [CFG_IDX_W-1:0] REG_BEYOND = 3'd4;

  localparam int DRAIN_CYCLES = 12;    // pipeline depth 4, plus cfg stall
  // cycles without any handshake before giving up; real gaps stay far below
  // the limit even with 80% idle on either end
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {CHK_PREDICT, CHK_RESULT, CHK_NONE} check_kind_t;
  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    check_kind_t kind;
    result_t     res;
  } word_check_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  op;
    pixel_t                pix;
    check_kind_t           chk;
    result_t               res;
    logic [CFG_IDX_W-1:0]  idx;
    logic [DIM_W-1:0]      data;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PIX_W-1:0]     s_axis_tdata  = '0;   // red_in, green_in, blue_in
  logic [0:0]           s_axis_tuser  = '0;   // op
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [PIX_W-1:0]     m_axis_tdata;         // red_out, green_out, blue_out
  logic                 m_axis_tlast;         // frame_end
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  sharpen_3x3_stream DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter model state
  // ---------------------------------------------------------------------------
  mode_t            cfg_mode;
  logic             cfg_gray;
  logic [DIM_W-1:0] cfg_width;
  logic [DIM_W-1:0] cfg_height;

  logic [PIX_W-1:0] line_prev  [MAX_WIDTH];
  logic [PIX_W-1:0] line_prev2 [MAX_WIDTH];
  logic [PIX_W-1:0] win [9];         // rows top to bottom, newest column right
  int unsigned      col_at, row_at, out_seen;

  result_t     expected_pixels [$];  // outputs still owed by the DUT
  word_check_t word_checks [$];      // how each driven word is to be checked
  int unsigned mismatches  = 0;
  int unsigned words_sent  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  // geometry of the random frames being sent
  int unsigned plan_w, plan_h;
  bit          plan_windowed;

  function automatic void frame_restart();
    col_at   = 0;
    row_at   = 0;
    out_seen = 0;
  endfunction

  function automatic void model_reset();
    cfg_mode   = MODE_OFF;
    cfg_gray   = 1'b0;
    cfg_width  = DIM_W'(RESET_WIDTH);
    cfg_height = DIM_W'(RESET_HEIGHT);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_prev[i]  = '0;
      line_prev2[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    frame_restart();
  endfunction

  // any write to a real register abandons the frame in flight
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DIM_W-1:0] val);
    case (idx)
      REG_MODE:   cfg_mode   = mode_t'(val[1:0]);
      REG_GRAY:   cfg_gray   = val[0];
      REG_WIDTH:  cfg_width  = val;
      REG_HEIGHT: cfg_height = val;
      default:    return;
    endcase
    frame_restart();
  endfunction

  function automatic int unsigned sat_size(input logic [DIM_W-1:0] v,
                                           input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // one channel of the window center; sh picks the byte lane
  function automatic logic [7:0] sharpen_chan(input int sh);
    int center, acc, q;
    center = int'(win[4][sh +: 8]);
    if (cfg_mode == MODE_UNSHARP) begin
      acc = 15 * center;
      for (int k = 0; k < 9; k++) acc = acc - int'(win[k][sh +: 8]);
      if (acc < 0) return 8'h00;
      q = acc / 6;
    end else begin
      acc = 6 * center - int'(win[1][sh +: 8]) - int'(win[7][sh +: 8])
                       - int'(win[3][sh +: 8]) - int'(win[5][sh +: 8]);
      if (acc < 0) return 8'h00;
      q = acc / 2;
    end
    if (q > 255) return 8'hFF;
    return q[7:0];
  endfunction

  // shift one pixel through line stores and window; output lags by w+1
  function automatic bit shift_in(input logic [PIX_W-1:0] px, input int unsigned w,
                                  input int unsigned h, output result_t res);
    int unsigned c, r, pr, pc;
    logic [PIX_W-1:0] above2, above;
    bit interior;
    res    = '0;
    c      = col_at;
    r      = row_at;
    above2 = line_prev2[c];
    above  = line_prev[c];
    line_prev2[c] = above;
    line_prev[c]  = px;
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = above2;
    win[5] = above;
    win[8] = px;
    col_at = c + 1;
    if (col_at >= w) begin
      col_at = 0;
      row_at = r + 1;
    end
    if (!(r >= 2 || (r == 1 && c >= 1))) return 1'b0;
    if (c >= 1) begin
      pr = r - 1;
      pc = c - 1;
    end else begin
      pr = r - 2;
      pc = w - 1;
    end
    interior = pr >= 1 && pr + 2 <= h && pc >= 1 && pc + 2 <= w;
    if (interior) begin
      res.red   = sharpen_chan(0);
      res.green = cfg_gray ? 8'h00 : sharpen_chan(8);
      res.blue  = cfg_gray ? 8'h00 : sharpen_chan(16);
    end else begin
      res.red   = win[4][7:0];
      res.green = win[4][15:8];
      res.blue  = win[4][23:16];
    end
    out_seen++;
    res.last = (out_seen >= w * h);
    if (res.last) frame_restart();
    return 1'b1;
  endfunction

  // expected output (if any) for one accepted input word
  function automatic bit sharpen_predict(input logic op, input pixel_t pin,
                                         output result_t res);
    int unsigned w, h;
    pixel_t px;
    bit windowed;
    res      = '0;
    w        = sat_size(cfg_width, MAX_WIDTH);
    h        = sat_size(cfg_height, MAX_HEIGHT);
    px.red   = pin.red;
    px.green = cfg_gray ? 8'h00 : pin.green;
    px.blue  = cfg_gray ? 8'h00 : pin.blue;
    windowed = (cfg_mode == MODE_UNSHARP || cfg_mode == MODE_LAPLACE) && w >= 3 && h >= 3;
    if (!windowed) begin
      if (op == OP_FLUSH) return 1'b0;
      res.red   = px.red;
      res.green = px.green;
      res.blue  = px.blue;
      out_seen++;
      res.last  = (out_seen >= w * h);
      if (res.last) frame_restart();
      return 1'b1;
    end
    if (op == OP_FLUSH) begin
      if (row_at < h) return 1'b0;     // frame not complete, or nothing pending
      return shift_in('0, w, h, res);
    end
    if (row_at >= h) frame_restart();   // new frame drops what is still pending
    return shift_in(px, w, h, res);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: config, input and output handshakes in one place so that a
  // same-edge input/output pair is always handled in a fixed order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    word_check_t chk;
    result_t     want;
    bit          has;
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) begin
        chk = word_checks.pop_front();
        has = sharpen_predict(s_axis_tuser[0], s_axis_tdata, want);
        if (chk.kind == CHK_RESULT) expected_pixels.push_back(chk.res);
        else if (chk.kind == CHK_PREDICT && has) expected_pixels.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("output word %h (last %b) with nothing expected", m_axis_tdata,
                 m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red_out",   32'(want.red),   32'(m_axis_tdata[7:0]));
          check_field("green_out", 32'(want.green), 32'(m_axis_tdata[15:8]));
          check_field("blue_out",  32'(want.blue),  32'(m_axis_tdata[23:16]));
          check_field("frame_end", 32'(want.last),  32'(m_axis_tlast));
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  // watchdog: any handshake resets the count
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic pixel_t random_pixel();
    pixel_t p;
    logic [7:0] ch [3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(7))
        0:       ch[i] = 8'h00;
        1:       ch[i] = 8'hFF;
        default: ch[i] = 8'($urandom_range(255));
      endcase
    end
    p.red   = ch[0];
    p.green = ch[1];
    p.blue  = ch[2];
    return p;
  endfunction

  // drives the word after random idle gaps and returns once it is taken
  task automatic send_word(input logic op, input pixel_t pix, input check_kind_t chk,
                           input result_t res);
    word_check_t wc;
    wc.kind = chk;
    wc.res  = res;
    word_checks.push_back(wc);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // all owed outputs in, then let a flush that produced nothing clear the pipe
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_setup();
    logic [DIM_W-1:0] junk, wv, hv;
    mode_t m;
    int unsigned pick;
    wait_idle();
    pick = $urandom_range(99);
    if (pick < 45)      m = MODE_UNSHARP;
    else if (pick < 85) m = MODE_LAPLACE;
    else if (pick < 93) m = MODE_OFF;
    else                m = MODE_RSVD;
    // mostly windowed sizes; now and then too small for a 3x3 window
    wv = ($urandom_range(99) < 85) ? DIM_W'($urandom_range(3, 6)) : DIM_W'($urandom_range(1, 2));
    hv = ($urandom_range(99) < 85) ? DIM_W'($urandom_range(3, 5)) : DIM_W'($urandom_range(1, 2));
    junk = DIM_W'($urandom);
    write_reg(REG_MODE, {junk[DIM_W-1:2], m});
    junk = DIM_W'($urandom);
    write_reg(REG_GRAY, junk);
    write_reg(REG_WIDTH, wv);
    write_reg(REG_HEIGHT, hv);
    if ($urandom_range(3) == 0)
      write_reg(REG_BEYOND + CFG_IDX_W'($urandom_range(3)), DIM_W'($urandom));
    plan_w        = 32'(wv);
    plan_h        = 32'(hv);
    plan_windowed = (m == MODE_UNSHARP || m == MODE_LAPLACE) && wv >= 3 && hv >= 3;
  endtask

  // mostly clean frames plus drain; some cut short, drained partly, or overflushed
  task automatic send_frame();
    int unsigned n_pix, n_flush, pick;
    n_pix   = plan_w * plan_h;
    n_flush = plan_windowed ? plan_w + 1 : $urandom_range(0, 2);
    pick    = $urandom_range(99);
    if (pick < 10)      n_pix   = $urandom_range(1, plan_w * plan_h);
    else if (pick < 20) n_flush = $urandom_range(0, plan_w);
    else if (pick < 25) n_flush = n_flush + $urandom_range(1, 3);
    for (int i = 0; i < n_pix; i++) begin
      if ($urandom_range(99) < 4) send_word(OP_FLUSH, random_pixel(), CHK_PREDICT, '0);
      send_word(OP_PIXEL, random_pixel(), CHK_PREDICT, '0);
    end
    for (int i = 0; i < n_flush; i++) send_word(OP_FLUSH, random_pixel(), CHK_PREDICT, '0);
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < budget) begin
      random_setup();
      repeat ($urandom_range(1, 3)) send_frame();
    end
  endtask

  // widest rows, tallest frames, a too-narrow width; a partial first row gives no result
  task automatic run_extremes();
    logic [DIM_W-1:0] junk;
    wait_idle();
    junk = DIM_W'($urandom);
    write_reg(REG_MODE, DIM_W'(MODE_LAPLACE));
    write_reg(REG_GRAY, junk);
    write_reg(REG_WIDTH, 12'hFFF);             // saturates to MAX_WIDTH
    write_reg(REG_HEIGHT, 12'd3);
    repeat (16) send_word(OP_PIXEL, random_pixel(), CHK_PREDICT, '0);
    wait_idle();
    write_reg(REG_MODE, DIM_W'(MODE_OFF));
    write_reg(REG_WIDTH, DIM_W'(MAX_WIDTH));
    write_reg(REG_HEIGHT, 12'hFFF);
    repeat (4) send_word(OP_PIXEL, random_pixel(), CHK_PREDICT, '0);
    wait_idle();
    write_reg(REG_MODE, DIM_W'(MODE_UNSHARP));
    write_reg(REG_WIDTH, 12'd1);               // too narrow for the window
    repeat (3) send_word(OP_PIXEL, random_pixel(), CHK_PREDICT, '0);
    send_word(OP_FLUSH, random_pixel(), CHK_PREDICT, '0);
  endtask

  // Directed table. Pixel literals are blue_green_red.
  plan_row_t directed_plan [31] = '{
    // out of reset: pass-through, 640x480, extremes per channel
    '{ROW_WORD, OP_PIXEL, 24'h00_ff_00, CHK_RESULT, '{8'h00, 8'hff, 8'h00, 1'b0}, '0, '0},
    '{ROW_WORD, OP_PIXEL, 24'hff_00_ff, CHK_RESULT, '{8'hff, 8'h00, 8'hff, 1'b0}, '0, '0},
    '{ROW_WORD, OP_FLUSH, 24'hc3_b2_a1, CHK_NONE,   '0, '0, '0},
    // gray: green and blue dropped
    '{ROW_REG,  OP_PIXEL, '0,           CHK_NONE,   '0, REG_GRAY, 12'h001},
    '{ROW_WORD, OP_PIXEL, 24'h56_34_12, CHK_RESULT, '{8'h12, 8'h00, 8'h00, 1'b0}, '0, '0},
    // width 0 saturates to 1: 1x1 frames, every word ends a frame
    '{ROW_REG,  OP_PIXEL, '0,           CHK_NONE,   '0, REG_WIDTH, 12'h000},
    '{ROW_REG,  OP_PIXEL, '0,           CHK_NONE,   '0, REG_HEIGHT, 12'h001},
    '{ROW_WORD, OP_PIXEL, 24'hcc_bb_aa, CHK_RESULT, '{8'haa, 8'h00, 8'h00, 1'b1}, '0, '0},
    // write past the register list changes nothing
    '{ROW_REG,  OP_PIXEL, '0,           CHK_NONE,   '0, REG_BEYOND, 12'hfff},
    '{ROW_WORD, OP_PIXEL, 24'h01_80_7f, CHK_RESULT, '{8'h7f, 8'h00, 8'h00, 1'b1}, '0, '0},
    // reserved mode behaves as off
    '{ROW_REG,  OP_PIXEL, '0,           CHK_NONE,   '0, REG_GRAY, 12'hffe},
    '{ROW_REG,  OP_PIXEL, '0,           CHK_NONE,   '0, REG_MODE, DIM_W'(MODE_RSVD)},
    '{ROW_WORD, OP_PIXEL, 24'h80_40_20, CHK_RESULT, '{8'h20, 8'h40, 8'h80, 1'b1}, '0, '0},
    // one 3x3 unsharp frame: bright red center, dark green center
    '{ROW_REG,  OP_PIXEL, '0,           CHK_NONE,   '0, REG_MODE, DIM_W'(MODE_UNSHARP)},
    '{ROW_REG,  OP_PIXEL, '0,           CHK_NONE,   '0, REG_WIDTH, 12'd3},
    '{ROW_REG,  OP_PIXEL, '0,           CHK_NONE,   '0, REG_HEIGHT, 12'd3},
    '{ROW_WORD, OP_PIXEL, 24'h10_ff_00, CHK_PREDICT, '0, '0, '0},
    '{ROW_WORD, OP_PIXEL, 24'h20_ff_00, CHK_PREDICT, '0, '0, '0},
    '{ROW_WORD, OP_PIXEL, 24'h30_ff_00, CHK_PREDICT, '0, '0, '0},
    '{ROW_WORD, OP_PIXEL, 24'h40_ff_00, CHK_PREDICT, '0, '0, '0},
    // flush before the frame is in: ignored
    '{ROW_WORD, OP_FLUSH, 24'h00_00_00, CHK_NONE,    '0, '0, '0},
    '{ROW_WORD, OP_PIXEL, 24'h80_00_ff, CHK_PREDICT, '0, '0, '0},
    '{ROW_WORD, OP_PIXEL, 24'h50_ff_00, CHK_PREDICT, '0, '0, '0},
    '{ROW_WORD, OP_PIXEL, 24'h60_ff_00, CHK_PREDICT, '0, '0, '0},
    '{ROW_WORD, OP_PIXEL, 24'h70_ff_00, CHK_PREDICT, '0, '0, '0},
    '{ROW_WORD, OP_PIXEL, 24'h90_ff_00, CHK_PREDICT, '0, '0, '0},
    '{ROW_WORD, OP_FLUSH, 24'hff_ff_ff, CHK_PREDICT, '0, '0, '0},
    '{ROW_WORD, OP_FLUSH, 24'h00_00_00, CHK_PREDICT, '0, '0, '0},
    '{ROW_WORD, OP_FLUSH, 24'hff_ff_ff, CHK_PREDICT, '0, '0, '0},
    '{ROW_WORD, OP_FLUSH, 24'h00_00_00, CHK_PREDICT, '0, '0, '0},
    // frame done: nothing left to release
    '{ROW_WORD, OP_FLUSH, 24'hff_ff_ff, CHK_NONE,    '0, '0, '0}
  };

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(directed_plan[i].idx, directed_plan[i].data);
      end else begin
        send_word(directed_plan[i].op, directed_plan[i].pix, directed_plan[i].chk,
                  directed_plan[i].res);
      end
    end

    // free-running
    run_extremes();
    run_phase(140);
    // sparse sender
    src_idle_pct = 80;
    run_phase(140);
    // slow receiver
    src_idle_pct   = 0;
    sink_stall_pct = 80;
    run_phase(140);
    // light jitter on both ends
    src_idle_pct   = 11;
    sink_stall_pct = 11;
    run_phase(140);

    wait_idle();
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ sharpen_3x3_stream.f @@
rtl/shp3_pkg.sv
rtl/sharpen_3x3_stream.sv
rtl/shp3_checker.sv
verif/testbench.sv
